// ===== hw/rtl/light_pair_matcher_unit_macros.svh =====
// assertion helpers for the matcher datapath rtl
`ifndef LIGHT_PAIR_MATCHER_UNIT_MACROS_SVH
`define LIGHT_PAIR_MATCHER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define LPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define LPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lpm_pkg.sv =====
package lpm_pkg;

  typedef struct packed {
    logic [1:0]         bar_color;
    logic signed [15:0] bar_angle;
    logic [14:0]        bar_length;
    logic [14:0]        center_x;
    logic [14:0]        center_y;
    logic               set_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0] left_slot;
    logic [2:0] right_slot;
    logic       accepted;
    logic [2:0] reject_reason;
    logic [1:0] armor_kind;
    logic       dropped_bars;
    logic       final_pair;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         color;
    logic signed [15:0] angle;
    logic [14:0]        length;
    logic [14:0]        cx;
    logic [14:0]        cy;
  } bar_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_RD_L, OP_RD_R, OP_LD_R, OP_PREP, OP_SQ_X, OP_SQ_Y, OP_ROOT_INIT,
    OP_ITER, OP_ROT_A, OP_ROT_B, OP_ROT_C, OP_ROT_D, OP_ROT_E,
    OP_M_LR, OP_C_LR, OP_M_X, OP_C_X, OP_M_Y, OP_C_Y,
    OP_M_DL, OP_C_DL, OP_M_DH, OP_C_DH, OP_M_K, OP_C_K, OP_EMIT
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD_L, ST_RD_R, ST_LD_R, ST_PREP, ST_SQ_X, ST_SQ_Y, ST_ROOT_INIT,
    ST_ITER, ST_ROT_A, ST_ROT_B, ST_ROT_C, ST_ROT_D, ST_ROT_E,
    ST_M_LR, ST_C_LR, ST_M_X, ST_C_X, ST_M_Y, ST_C_Y,
    ST_M_DL, ST_C_DL, ST_M_DH, ST_C_DH, ST_M_K, ST_C_K, ST_EMIT
  } state_t;

  typedef struct packed {
    op_t  op;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic close_pairs;
    logic iter_done;
    logic last_pair;
    logic out_free;
  } status_t;

  localparam logic [2:0] REG_TARGET_COLOR = 3'd0;
  localparam logic [2:0] REG_MAX_ANGLE    = 3'd1;
  localparam logic [2:0] REG_MIN_LEN      = 3'd2;
  localparam logic [2:0] REG_MIN_X        = 3'd3;
  localparam logic [2:0] REG_MAX_Y        = 3'd4;
  localparam logic [2:0] REG_MIN_DIST     = 3'd5;
  localparam logic [2:0] REG_MAX_DIST     = 3'd6;
  localparam logic [2:0] REG_LARGE_DIST   = 3'd7;

  localparam logic [1:0]  RST_TARGET_COLOR = 2'd0;
  localparam logic [15:0] RST_MAX_ANGLE    = 16'd1820;
  localparam logic [15:0] RST_MIN_LEN      = 16'd179;
  localparam logic [15:0] RST_MIN_X        = 16'd0;
  localparam logic [15:0] RST_MAX_Y        = 16'd256;
  localparam logic [15:0] RST_MIN_DIST     = 16'd26;
  localparam logic [15:0] RST_MAX_DIST     = 16'd256;
  localparam logic [15:0] RST_LARGE_DIST   = 16'd819;

  localparam logic [2:0] RSN_NONE   = 3'd0;
  localparam logic [2:0] RSN_COLOR  = 3'd1;
  localparam logic [2:0] RSN_DEGEN  = 3'd2;
  localparam logic [2:0] RSN_ANGLE  = 3'd3;
  localparam logic [2:0] RSN_LENGTH = 3'd4;
  localparam logic [2:0] RSN_X      = 3'd5;
  localparam logic [2:0] RSN_Y      = 3'd6;
  localparam logic [2:0] RSN_DIST   = 3'd7;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_SMALL = 2'd1;
  localparam logic [1:0] KIND_LARGE = 2'd2;

  localparam logic [4:0]         CORDIC_STEPS = 5'd14;
  localparam logic [4:0]         ROOT_LAST    = 5'd20;
  localparam logic signed [17:0] CORDIC_X0    = 18'sd9949;

  function automatic logic signed [17:0] cordic_atan(input logic [3:0] i);
    logic signed [17:0] v;
    case (i)
      4'd0:    v = 18'sd8192;
      4'd1:    v = 18'sd4836;
      4'd2:    v = 18'sd2555;
      4'd3:    v = 18'sd1297;
      4'd4:    v = 18'sd651;
      4'd5:    v = 18'sd326;
      4'd6:    v = 18'sd163;
      4'd7:    v = 18'sd81;
      4'd8:    v = 18'sd41;
      4'd9:    v = 18'sd20;
      4'd10:   v = 18'sd10;
      4'd11:   v = 18'sd5;
      4'd12:   v = 18'sd3;
      4'd13:   v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/lpm_ram.sv =====
module lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lpm_ctrl.sv =====
module lpm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  lpm_pkg::status_t status,
  output lpm_pkg::cmd_t    cmd,
  output logic             in_stall
);
  import lpm_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    cmd.load   = (state == ST_IDLE) && in_valid;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid && status.close_pairs) state_next = ST_RD_L;
      end
      ST_RD_L:      begin cmd.op = OP_RD_L;      state_next = ST_RD_R;      end
      ST_RD_R:      begin cmd.op = OP_RD_R;      state_next = ST_LD_R;      end
      ST_LD_R:      begin cmd.op = OP_LD_R;      state_next = ST_PREP;      end
      ST_PREP:      begin cmd.op = OP_PREP;      state_next = ST_SQ_X;      end
      ST_SQ_X:      begin cmd.op = OP_SQ_X;      state_next = ST_SQ_Y;      end
      ST_SQ_Y:      begin cmd.op = OP_SQ_Y;      state_next = ST_ROOT_INIT; end
      ST_ROOT_INIT: begin cmd.op = OP_ROOT_INIT; state_next = ST_ITER;      end
      ST_ITER: begin
        cmd.op = OP_ITER;
        if (status.iter_done) state_next = ST_ROT_A;
      end
      ST_ROT_A: begin cmd.op = OP_ROT_A; state_next = ST_ROT_B; end
      ST_ROT_B: begin cmd.op = OP_ROT_B; state_next = ST_ROT_C; end
      ST_ROT_C: begin cmd.op = OP_ROT_C; state_next = ST_ROT_D; end
      ST_ROT_D: begin cmd.op = OP_ROT_D; state_next = ST_ROT_E; end
      ST_ROT_E: begin cmd.op = OP_ROT_E; state_next = ST_M_LR;  end
      ST_M_LR:  begin cmd.op = OP_M_LR;  state_next = ST_C_LR;  end
      ST_C_LR:  begin cmd.op = OP_C_LR;  state_next = ST_M_X;   end
      ST_M_X:   begin cmd.op = OP_M_X;   state_next = ST_C_X;   end
      ST_C_X:   begin cmd.op = OP_C_X;   state_next = ST_M_Y;   end
      ST_M_Y:   begin cmd.op = OP_M_Y;   state_next = ST_C_Y;   end
      ST_C_Y:   begin cmd.op = OP_C_Y;   state_next = ST_M_DL;  end
      ST_M_DL:  begin cmd.op = OP_M_DL;  state_next = ST_C_DL;  end
      ST_C_DL:  begin cmd.op = OP_C_DL;  state_next = ST_M_DH;  end
      ST_M_DH:  begin cmd.op = OP_M_DH;  state_next = ST_C_DH;  end
      ST_C_DH:  begin cmd.op = OP_C_DH;  state_next = ST_M_K;   end
      ST_M_K:   begin cmd.op = OP_M_K;   state_next = ST_C_K;   end
      ST_C_K:   begin cmd.op = OP_C_K;   state_next = ST_EMIT;  end
      ST_EMIT: begin
        cmd.op = OP_EMIT;
        if (status.out_free) state_next = status.last_pair ? ST_IDLE : ST_RD_L;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/lpm_datapath.sv =====
`include "light_pair_matcher_unit_macros.svh"

module lpm_datapath #(
  parameter int MAX_LIGHTS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  lpm_pkg::cmd_t       cmd,
  output lpm_pkg::status_t    status,
  input  lpm_pkg::in_item_t   in_item,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpm_pkg::out_item_t  out_item
);
  import lpm_pkg::*;

  localparam int IW = $clog2(MAX_LIGHTS);
  localparam int CW = $clog2(MAX_LIGHTS + 1);

  // configuration
  logic [1:0]  reg_target_color;
  logic [15:0] reg_max_angle, reg_min_len, reg_min_x, reg_max_y;
  logic [15:0] reg_min_dist, reg_max_dist, reg_large_dist;

  // frame bookkeeping
  logic [CW-1:0] count, count_after;
  logic          overflow;
  logic          room;
  logic [IW-1:0] sorted_idx [MAX_LIGHTS];
  logic [14:0]   sorted_cx  [MAX_LIGHTS];
  logic [IW-1:0] sorted_idx_next [MAX_LIGHTS];
  logic [14:0]   sorted_cx_next  [MAX_LIGHTS];
  logic [MAX_LIGHTS-1:0] le;
  logic [CW-1:0] pos;
  logic [IW-1:0] pi, pj, sel_slot;
  logic          last_j, last_pair;

  // bar store
  logic [$bits(bar_t)-1:0] ram_rdata;
  bar_t lbar, rbar, new_bar;

  // pair geometry
  logic signed [15:0] gx, gy;
  logic [15:0] ssum, fold;
  logic [14:0] mn, mx;
  logic        color_ok;
  logic [14:0] dsub;
  logic [15:0] dneg;

  logic signed [18:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [40:0] mul_res, prod, acc, sq_sum, rot_diff, rot_sum;
  logic [40:0] uprod, lx, ly;

  logic [41:0] rem, res, bitv, trial;
  logic [4:0]  step;
  logic signed [17:0] cx_r, cy_r, cz_r, xs, ys, ang;
  logic        flip;
  logic signed [18:0] cos_v, sin_v;
  logic [20:0] dist8;

  logic lr_fail, x_fail, y_fail, dlo_fail, dhi_fail, is_large;
  logic emit_fire;
  logic [2:0] reason;
  logic [1:0] kind;

  assign new_bar = '{color: in_item.bar_color, angle: in_item.bar_angle,
                     length: in_item.bar_length, cx: in_item.center_x,
                     cy: in_item.center_y};

  assign room        = count < CW'(MAX_LIGHTS);
  assign count_after = room ? count + CW'(1) : count;

  // sorted insertion point: entries with cx not above the new one stay in front
  always_comb begin
    for (int k = 0; k < MAX_LIGHTS; k++) begin
      le[k] = (CW'(k) < count) && (sorted_cx[k] <= in_item.center_x);
    end
    pos = CW'($countones(le));
    sorted_idx_next[0] = (pos == '0) ? IW'(count) : sorted_idx[0];
    sorted_cx_next[0]  = (pos == '0) ? in_item.center_x : sorted_cx[0];
    for (int k = 1; k < MAX_LIGHTS; k++) begin
      if (CW'(k) < pos) begin
        sorted_idx_next[k] = sorted_idx[k];
        sorted_cx_next[k]  = sorted_cx[k];
      end else if (CW'(k) == pos) begin
        sorted_idx_next[k] = IW'(count);
        sorted_cx_next[k]  = in_item.center_x;
      end else begin
        sorted_idx_next[k] = sorted_idx[k-1];
        sorted_cx_next[k]  = sorted_cx[k-1];
      end
    end
  end

  assign sel_slot  = (cmd.op == OP_RD_R) ? pj : pi;
  assign last_j    = (pj == IW'(count - CW'(1)));
  assign last_pair = last_j && (pi == IW'(count - CW'(2)));

  lpm_ram #(.WIDTH($bits(bar_t)), .DEPTH(MAX_LIGHTS)) u_bar_ram (
    .clk   (clk),
    .we    (cmd.load && room),
    .waddr (IW'(count)),
    .wdata (new_bar),
    .raddr (sorted_idx[sel_slot]),
    .rdata (ram_rdata)
  );

  // angle fold
  assign dsub = lbar.angle[14:0] - rbar.angle[14:0];
  assign dneg = 16'd32768 - {1'b0, dsub};

  // sin and cos with the half-turn flip applied
  assign cos_v = flip ? -{cx_r[17], cx_r} : {cx_r[17], cx_r};
  assign sin_v = flip ? -{cy_r[17], cy_r} : {cy_r[17], cy_r};
  assign xs    = cx_r >>> step[3:0];
  assign ys    = cy_r >>> step[3:0];
  assign ang   = {{2{lbar.angle[15]}}, lbar.angle};

  assign bitv  = 42'd1 << (6'd40 - {step, 1'b0});
  assign trial = res + bitv;
  assign dist8 = res[20:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQ_X: begin mul_a = {{3{gx[15]}}, gx}; mul_b = {{6{gx[15]}}, gx}; end
      OP_SQ_Y: begin mul_a = {{3{gy[15]}}, gy}; mul_b = {{6{gy[15]}}, gy}; end
      OP_ROT_A: begin mul_a = {{3{gy[15]}}, gy}; mul_b = {{3{cos_v[18]}}, cos_v}; end
      OP_ROT_B: begin mul_a = {{3{gx[15]}}, gx}; mul_b = {{3{sin_v[18]}}, sin_v}; end
      OP_ROT_C: begin mul_a = {{3{gx[15]}}, gx}; mul_b = {{3{cos_v[18]}}, cos_v}; end
      OP_ROT_D: begin mul_a = {{3{gy[15]}}, gy}; mul_b = {{3{sin_v[18]}}, sin_v}; end
      OP_M_LR: begin mul_a = {3'b0, reg_min_len}; mul_b = {7'b0, mx}; end
      OP_M_X:  begin mul_a = {3'b0, reg_min_x}; mul_b = {1'b0, ssum, 5'b0}; end
      OP_M_Y:  begin mul_a = {2'b0, {1'b0, reg_max_y} + 17'd1}; mul_b = {1'b0, ssum, 5'b0}; end
      OP_M_DL: begin mul_a = {3'b0, reg_min_dist}; mul_b = {1'b0, dist8}; end
      OP_M_DH: begin mul_a = {2'b0, {1'b0, reg_max_dist} + 17'd1}; mul_b = {1'b0, dist8}; end
      OP_M_K:  begin
        mul_a = {2'b0, {1'b0, reg_large_dist} + 17'd1};
        mul_b = {6'b0, ssum};
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_res  = mul_a * mul_b;
  assign uprod    = $unsigned(prod);
  assign sq_sum   = acc + prod;
  assign rot_diff = acc - prod;
  assign rot_sum  = acc + prod;

  // verdict
  always_comb begin
    reason = RSN_NONE;
    kind   = KIND_NONE;
    if (!color_ok) begin
      reason = RSN_COLOR;
    end else if (ssum == '0 || res == '0) begin
      reason = RSN_DEGEN;
    end else begin
      kind = is_large ? KIND_LARGE : KIND_SMALL;
      if (fold > reg_max_angle)      reason = RSN_ANGLE;
      else if (lr_fail)              reason = RSN_LENGTH;
      else if (x_fail)               reason = RSN_X;
      else if (y_fail)               reason = RSN_Y;
      else if (dlo_fail || dhi_fail) reason = RSN_DIST;
      else                           reason = RSN_NONE;
    end
  end

  assign emit_fire = (cmd.op == OP_EMIT) && status.out_free;

  assign status.close_pairs = in_item.set_end && (count_after >= CW'(2));
  assign status.iter_done   = (step == ROOT_LAST);
  assign status.last_pair   = last_pair;
  assign status.out_free    = !out_valid || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_target_color <= RST_TARGET_COLOR;
      reg_max_angle    <= RST_MAX_ANGLE;
      reg_min_len      <= RST_MIN_LEN;
      reg_min_x        <= RST_MIN_X;
      reg_max_y        <= RST_MAX_Y;
      reg_min_dist     <= RST_MIN_DIST;
      reg_max_dist     <= RST_MAX_DIST;
      reg_large_dist   <= RST_LARGE_DIST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TARGET_COLOR: reg_target_color <= cfg_data[1:0];
        REG_MAX_ANGLE:    reg_max_angle    <= cfg_data;
        REG_MIN_LEN:      reg_min_len      <= cfg_data;
        REG_MIN_X:        reg_min_x        <= cfg_data;
        REG_MAX_Y:        reg_max_y        <= cfg_data;
        REG_MIN_DIST:     reg_min_dist     <= cfg_data;
        REG_MAX_DIST:     reg_max_dist     <= cfg_data;
        REG_LARGE_DIST:   reg_large_dist   <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame control
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (in_item.set_end && count_after < CW'(2)) begin
          count    <= '0;
          overflow <= 1'b0;
        end else begin
          count    <= count_after;
          overflow <= overflow || !room;
        end
      end else if (emit_fire && last_pair) begin
        count    <= '0;
        overflow <= 1'b0;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      sorted_idx <= sorted_idx_next;
      sorted_cx  <= sorted_cx_next;
    end
    if (cmd.load) begin
      pi <= '0;
      pj <= IW'(1);
    end
    case (cmd.op)
      OP_RD_R: lbar <= bar_t'(ram_rdata);
      OP_LD_R: rbar <= bar_t'(ram_rdata);
      OP_PREP: begin
        gx       <= $signed({1'b0, rbar.cx}) - $signed({1'b0, lbar.cx});
        gy       <= $signed({1'b0, rbar.cy}) - $signed({1'b0, lbar.cy});
        ssum     <= {1'b0, lbar.length} + {1'b0, rbar.length};
        mx       <= (lbar.length > rbar.length) ? lbar.length : rbar.length;
        mn       <= (lbar.length > rbar.length) ? rbar.length : lbar.length;
        fold     <= ({1'b0, dsub} < dneg) ? {1'b0, dsub} : dneg;
        color_ok <= (lbar.color == rbar.color) && (lbar.color == reg_target_color);
      end
      OP_SQ_X: prod <= mul_res;
      OP_SQ_Y: begin acc <= prod; prod <= mul_res; end
      OP_ROOT_INIT: begin
        rem  <= {sq_sum[33:0], 8'b0};
        res  <= '0;
        step <= '0;
        cx_r <= CORDIC_X0;
        cy_r <= '0;
        if (ang > 18'sd16384) begin
          cz_r <= ang - 18'sd32768;
          flip <= 1'b1;
        end else if (ang < -18'sd16384) begin
          cz_r <= ang + 18'sd32768;
          flip <= 1'b1;
        end else begin
          cz_r <= ang;
          flip <= 1'b0;
        end
      end
      OP_ITER: begin
        step <= step + 5'd1;
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        if (step < CORDIC_STEPS) begin
          if (!cz_r[17]) begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            cz_r <= cz_r - cordic_atan(step[3:0]);
          end else begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            cz_r <= cz_r + cordic_atan(step[3:0]);
          end
        end
      end
      OP_ROT_A: prod <= mul_res;
      OP_ROT_B: begin acc <= prod; prod <= mul_res; end
      OP_ROT_C: begin
        lx   <= rot_diff[40] ? $unsigned(-rot_diff) : $unsigned(rot_diff);
        prod <= mul_res;
      end
      OP_ROT_D: begin acc <= prod; prod <= mul_res; end
      OP_ROT_E: ly <= rot_sum[40] ? $unsigned(-rot_sum) : $unsigned(rot_sum);
      OP_M_LR, OP_M_X, OP_M_Y, OP_M_DL, OP_M_DH, OP_M_K: prod <= mul_res;
      OP_C_LR: lr_fail  <= {18'b0, mn, 8'b0} < uprod;
      OP_C_X:  x_fail   <= lx < uprod;
      OP_C_Y:  y_fail   <= ly >= uprod;
      OP_C_DL: dlo_fail <= {14'b0, ssum, 11'b0} < uprod;
      OP_C_DH: dhi_fail <= {14'b0, ssum, 11'b0} >= uprod;
      OP_C_K:  is_large <= {15'b0, dist8, 5'b0} >= uprod;
      OP_EMIT: begin
        if (emit_fire) begin
          out_item.left_slot     <= 3'(pi);
          out_item.right_slot    <= 3'(pj);
          out_item.accepted      <= (reason == RSN_NONE);
          out_item.reject_reason <= reason;
          out_item.armor_kind    <= kind;
          out_item.dropped_bars  <= overflow;
          out_item.final_pair    <= last_pair;
          if (last_j) begin
            pi <= pi + IW'(1);
            pj <= pi + IW'(2);
          end else begin
            pj <= pj + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  `LPM_ASSERT_NEXT(a_emit_shows, emit_fire, out_valid, "verdict not presented after emit")
  `LPM_ASSERT_NOW(a_ovf_full, overflow, count == CW'(MAX_LIGHTS), "overflow below capacity")
  `LPM_ASSERT_NOW(a_accept_kind, out_valid && out_item.accepted, out_item.armor_kind != KIND_NONE, "accepted pair has no kind")
  `LPM_ASSERT_NOW(a_pair_order, out_valid, out_item.left_slot < out_item.right_slot, "pair slots out of order")

endmodule

// ===== hw/rtl/light_pair_matcher_unit.sv =====
// a bar is taken while the sequencer idles; each pair verdict can be held by output stalls
// the input stalls while the pairs of a frame run
// the per-pair time is set by the 21-step shared root/cordic loop and the single multiplier
// reset: synchronous, clears control, bar count, overflow flag and config to defaults
module light_pair_matcher_unit #(
  parameter int MAX_LIGHTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  // bar input
  input  logic               in_valid,
  output logic               in_stall,
  input  lpm_pkg::in_item_t  in_item,
  // verdict output
  output logic               out_valid,
  input  logic               out_stall,
  output lpm_pkg::out_item_t out_item,
  // configuration writes
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import lpm_pkg::*;

  // command and status between sequencer and datapath
  cmd_t    cmd;
  status_t status;

  // sequencer: takes bars while idle, then steps each pair through
  // read, geometry, root/cordic loop, rotation, ratio checks and emit
  lpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // datapath: bar ram, sorted slot list, shared multiplier,
  // root and cordic iterations, config registers and the output register
  lpm_datapath #(.MAX_LIGHTS(MAX_LIGHTS)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== tb/light_pair_matcher_unit_tb.sv =====
module light_pair_matcher_unit_tb;
  import lpm_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  light_pair_matcher_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int NUM_SLOTS = 8;
  localparam int IDLE_LIMIT = 20000;

  // predictor copy of the block state
  bar_t        frame_bars[NUM_SLOTS];
  int          frame_count;
  logic        frame_dropped;
  logic [15:0] thresholds[8];

  in_item_t  pending_bars[$];
  out_item_t expected_verdicts[$];

  int error_count;
  int verdicts_seen;
  int frames_closed;
  int accepted_pairs;
  int idle_cycles;
  int sender_idle_pct;
  int receiver_stall_pct;
  logic sender_hold;
  logic hold_go;
  logic long_hold;

  initial begin
    clk = 1'b0;
  end
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (verdict %0d)", what, got, want, verdicts_seen);
    error_count++;
  endtask

  // floor division of a signed value by a power of two
  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  task automatic rotate_unit(input int a, output longint c, output longint s);
    int atan_step[14];
    longint x, y, z, nx;
    logic flip;
    atan_step = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    x = 9949;
    y = 0;
    z = a;
    flip = 1'b0;
    if (z > 16384) begin
      z -= 32768; flip = 1'b1;
    end else if (z < -16384) begin
      z += 32768; flip = 1'b1;
    end
    for (int i = 0; i < 14; i++) begin
      if (z >= 0) begin
        nx = x - floor_shr(y, i);
        y = y + floor_shr(x, i);
        z -= atan_step[i];
      end else begin
        nx = x + floor_shr(y, i);
        y = y - floor_shr(x, i);
        z += atan_step[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint int_root(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 40;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  task automatic judge_pair(input bar_t l, input bar_t r,
                            output logic [2:0] reason, output logic [1:0] kind);
    int d, fold;
    longint c, s, gx, gy, lx, ly, mx, mn, lr, xr, yr, sum_len, root_d, dbl, dr;
    kind = KIND_NONE;
    if (l.color != r.color || l.color != thresholds[REG_TARGET_COLOR][1:0]) begin
      reason = RSN_COLOR;
      return;
    end
    d = (int'(l.angle) - int'(r.angle)) & 32'h7FFF;
    fold = (d < 32768 - d) ? d : 32768 - d;
    mx = (l.length > r.length) ? l.length : r.length;
    mn = (l.length > r.length) ? r.length : l.length;
    lr = (mx != 0) ? (mn * 256) / mx : 0;
    gx = longint'(r.cx) - longint'(l.cx);
    gy = longint'(r.cy) - longint'(l.cy);
    rotate_unit(int'(l.angle), c, s);
    lx = gy * c - gx * s;
    if (lx < 0) lx = -lx;
    ly = gx * c + gy * s;
    if (ly < 0) ly = -ly;
    sum_len = longint'(l.length) + longint'(r.length);
    xr = (sum_len != 0) ? lx / (32 * sum_len) : 0;
    yr = (sum_len != 0) ? ly / (32 * sum_len) : 0;
    root_d = int_root((gx * gx + gy * gy) << 8);
    if (root_d == 0 || sum_len == 0) begin
      reason = RSN_DEGEN;
      return;
    end
    dbl = (32 * root_d) / sum_len;
    dr = (2048 * sum_len) / root_d;
    kind = (dbl > thresholds[REG_LARGE_DIST]) ? KIND_LARGE : KIND_SMALL;
    if (fold > thresholds[REG_MAX_ANGLE]) reason = RSN_ANGLE;
    else if (lr < thresholds[REG_MIN_LEN]) reason = RSN_LENGTH;
    else if (xr < thresholds[REG_MIN_X]) reason = RSN_X;
    else if (yr > thresholds[REG_MAX_Y]) reason = RSN_Y;
    else if (dr < thresholds[REG_MIN_DIST] || dr > thresholds[REG_MAX_DIST]) reason = RSN_DIST;
    else reason = RSN_NONE;
  endtask

  // one accepted bar: store it and, on the closing bar, queue the pair verdicts
  task automatic predict_bar(input in_item_t b);
    int order[NUM_SLOTS];
    int k;
    int first_new;
    out_item_t v;
    logic [2:0] reason;
    logic [1:0] kind;
    if (frame_count < NUM_SLOTS) begin
      frame_bars[frame_count] = '{b.bar_color, b.bar_angle, b.bar_length, b.center_x, b.center_y};
      frame_count++;
    end else begin
      frame_dropped = 1'b1;
    end
    if (!b.set_end) return;
    frames_closed++;
    // stable insertion sort on center x
    for (int i = 0; i < frame_count; i++) begin
      k = i;
      while (k > 0 && frame_bars[order[k-1]].cx > frame_bars[i].cx) begin
        order[k] = order[k-1];
        k--;
      end
      order[k] = i;
    end
    first_new = expected_verdicts.size();
    for (int i = 0; i < frame_count; i++) begin
      for (int j = i + 1; j < frame_count; j++) begin
        judge_pair(frame_bars[order[i]], frame_bars[order[j]], reason, kind);
        v.left_slot = i[2:0];
        v.right_slot = j[2:0];
        v.accepted = (reason == RSN_NONE);
        v.reject_reason = reason;
        v.armor_kind = kind;
        v.dropped_bars = frame_dropped;
        v.final_pair = 1'b0;
        if (reason == RSN_NONE) accepted_pairs++;
        expected_verdicts = {expected_verdicts, v};
      end
    end
    if (expected_verdicts.size() > first_new)
      expected_verdicts[expected_verdicts.size()-1].final_pair = 1'b1;
    frame_count = 0;
    frame_dropped = 1'b0;
  endtask

  // driver: a valid item stays put until its transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_bar(in_item);
        void'(pending_bars.pop_front());
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (pending_bars.size() > 0 && !sender_hold &&
                   $urandom_range(99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        in_item <= pending_bars[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold, counted here while the sender keeps offering bars
  initial begin
    long_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (400) @(posedge clk);
    long_hold <= 1'b0;
  end

  // monitor: check each verdict transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("unexpected verdict", 1, 0);
        end else begin
          out_item_t e;
          e = expected_verdicts.pop_front();
          if (out_item.left_slot !== e.left_slot)
            report_mismatch("left_slot", out_item.left_slot, e.left_slot);
          if (out_item.right_slot !== e.right_slot)
            report_mismatch("right_slot", out_item.right_slot, e.right_slot);
          if (out_item.accepted !== e.accepted)
            report_mismatch("accepted", out_item.accepted, e.accepted);
          if (out_item.reject_reason !== e.reject_reason)
            report_mismatch("reject_reason", out_item.reject_reason, e.reject_reason);
          if (out_item.armor_kind !== e.armor_kind)
            report_mismatch("armor_kind", out_item.armor_kind, e.armor_kind);
          if (out_item.dropped_bars !== e.dropped_bars)
            report_mismatch("dropped_bars", out_item.dropped_bars, e.dropped_bars);
          if (out_item.final_pair !== e.final_pair)
            report_mismatch("final_pair", out_item.final_pair, e.final_pair);
        end
        verdicts_seen++;
      end
      if (long_hold) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic in_item_t rand_bar(input logic closing, input logic [1:0] color);
    in_item_t b;
    b.bar_color = color;
    b.bar_angle = 16'($urandom_range(32768) - 16384);
    b.bar_length = 15'($urandom_range(32767));
    b.center_x = 15'($urandom_range(32767));
    b.center_y = 15'($urandom_range(32767));
    b.set_end = closing;
    return b;
  endfunction

  // plausible light bar near a partner so geometry checks get exercised
  function automatic in_item_t near_bar(input in_item_t ref_bar, input logic closing);
    in_item_t b;
    b = ref_bar;
    b.bar_angle = 16'(int'(ref_bar.bar_angle) + $urandom_range(600) - 300);
    if ($urandom_range(3) == 0) b.bar_angle = 16'($urandom_range(32768) - 16384);
    b.bar_length = 15'(int'(ref_bar.bar_length) + $urandom_range(200) - 100);
    b.center_x = 15'(int'(ref_bar.center_x) + $urandom_range(2000));
    b.center_y = 15'(int'(ref_bar.center_y) + $urandom_range(400) - 200);
    b.set_end = closing;
    return b;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    thresholds[idx] = (idx == REG_TARGET_COLOR) ? {14'd0, val[1:0]} : val;
  endtask

  task automatic wait_drained();
    while (pending_bars.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    // bars that close short frames produce nothing, so give the block time to settle
    repeat (60) @(posedge clk);
  endtask

  // random frame: mostly well-formed, sometimes short or overfull
  task automatic queue_frame(input logic [1:0] color);
    int n;
    in_item_t prev;
    n = $urandom_range(9) == 0 ? $urandom_range(12, 9) : $urandom_range(4, 2);
    if ($urandom_range(15) == 0) n = 1;
    prev = rand_bar(1'b0, color);
    prev.bar_length = 15'($urandom_range(1200, 100));
    prev.center_x = 15'($urandom_range(20000));
    prev.center_y = 15'($urandom_range(30000));
    for (int i = 0; i < n; i++) begin
      if (i > 0) prev = ($urandom_range(4) == 0) ? rand_bar(1'b0, 2'($urandom_range(3)))
                                                 : near_bar(prev, 1'b0);
      if ($urandom_range(9) == 0) prev.bar_color = 2'($urandom_range(3));
      prev.set_end = (i == n - 1);
      pending_bars = {pending_bars, prev};
    end
  endtask

  initial begin
    in_item_t b;
    int phase_bars;
    logic paused;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_TARGET_COLOR;
    cfg_data = '0;
    sender_hold = 1'b0;
    hold_go = 1'b0;
    paused = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    error_count = 0;
    verdicts_seen = 0;
    frames_closed = 0;
    accepted_pairs = 0;
    idle_cycles = 0;
    frame_count = 0;
    frame_dropped = 1'b0;
    thresholds = '{16'(RST_TARGET_COLOR), RST_MAX_ANGLE, RST_MIN_LEN, RST_MIN_X,
                   RST_MAX_Y, RST_MIN_DIST, RST_MAX_DIST, RST_LARGE_DIST};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, zero lengths, coincident centers, ties in x, overflow
    b = '{2'd0, 16'sd16384, 15'd32767, 15'd0, 15'd0, 1'b0};
    pending_bars = {pending_bars, b};
    b = '{2'd0, -16'sd16384, 15'd0, 15'd32767, 15'd32767, 1'b0};
    pending_bars = {pending_bars, b};
    b = '{2'd0, 16'sd0, 15'd0, 15'd100, 15'd100, 1'b0};
    pending_bars = {pending_bars, b};
    b = '{2'd0, 16'sd0, 15'd0, 15'd100, 15'd100, 1'b1};
    pending_bars = {pending_bars, b};
    b = '{2'd0, 16'sd0, 15'd400, 15'd500, 15'd500, 1'b1};
    pending_bars = {pending_bars, b};
    for (int i = 0; i < 10; i++) begin
      b = '{2'(i % 4 == 3 ? 1 : 0), 16'(i * 700 - 3000), 15'(400 + i * 20),
            15'(i == 4 ? 1000 : 6000 - i * 500), 15'(2000 + i * 10), 1'(i == 9)};
      pending_bars = {pending_bars, b};
    end
    b = '{2'd3, 16'sd100, 15'd300, 15'd1000, 15'd1000, 1'b0};
    pending_bars = {pending_bars, b};
    b = '{2'd3, -16'sd100, 15'd320, 15'd3000, 15'd1010, 1'b1};
    pending_bars = {pending_bars, b};
    b = '{2'd0, 16'sd200, 15'd300, 15'd1000, 15'd1000, 1'b0};
    pending_bars = {pending_bars, b};
    b = '{2'd0, -16'sd150, 15'd300, 15'd1800, 15'd1050, 1'b1};
    pending_bars = {pending_bars, b};
    wait_drained();

    // random phases, each under a register setting and one of four idling mixes
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
        default: begin sender_idle_pct = 24; receiver_stall_pct = 24; end
      endcase
      if (phase == 6) begin
        write_reg(REG_TARGET_COLOR, 16'd3);
        write_reg(REG_MAX_ANGLE, 16'd32768);
        write_reg(REG_MIN_LEN, 16'd0);
        write_reg(REG_MIN_X, 16'd0);
        write_reg(REG_MAX_Y, 16'hFFFF);
        write_reg(REG_MIN_DIST, 16'd0);
        write_reg(REG_MAX_DIST, 16'hFFFF);
        write_reg(REG_LARGE_DIST, 16'd0);
      end else if (phase == 7) begin
        write_reg(REG_MAX_ANGLE, 16'd0);
        write_reg(REG_MIN_LEN, 16'hFFFF);
        write_reg(REG_MIN_X, 16'hFFFF);
        write_reg(REG_MAX_Y, 16'd0);
        write_reg(REG_LARGE_DIST, 16'hFFFF);
      end else if (phase > 0) begin
        write_reg(REG_TARGET_COLOR, 16'($urandom_range(3)));
        write_reg(REG_MAX_ANGLE, 16'($urandom_range(4000)));
        write_reg(REG_MIN_LEN, 16'($urandom_range(230)));
        write_reg(REG_MIN_X, 16'($urandom_range(300)));
        write_reg(REG_MAX_Y, 16'($urandom_range(60, 400)));
        write_reg(REG_MIN_DIST, 16'($urandom_range(60)));
        write_reg(REG_MAX_DIST, 16'($urandom_range(100, 600)));
        write_reg(REG_LARGE_DIST, 16'($urandom_range(400, 1200)));
      end
      phase_bars = 0;
      while (phase_bars < 42) begin
        queue_frame(2'(thresholds[REG_TARGET_COLOR]));
        // long receiver hold while the sender keeps offering bars
        if (phase == 2 && !hold_go && pending_bars.size() >= 2) hold_go = 1'b1;
        phase_bars = pending_bars.size() + phase_bars;
        while (pending_bars.size() > 0) @(posedge clk);
        // one pause with the sender held until the block has drained
        if (phase == 5 && !paused && expected_verdicts.size() != 0) begin
          paused = 1'b1;
          sender_hold = 1'b1;
          while (expected_verdicts.size() != 0) @(posedge clk);
          sender_hold = 1'b0;
        end
      end
      wait_drained();
    end

    $display("covered %0d frames, %0d pair verdicts, %0d accepted pairs",
             frames_closed, verdicts_seen, accepted_pairs);
    $display("register extremes and four sender/receiver idling mixes were exercised");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
